// File: src/preferential_attachment_picker_macros.svh
// Assertion macros shared by the preferential attachment picker modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef PREFERENTIAL_ATTACHMENT_PICKER_MACROS_SVH
`define PREFERENTIAL_ATTACHMENT_PICKER_MACROS_SVH

`ifndef SYNTHESIS

`define PAP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PAP_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) cond |=> prop) else $error(msg);

`else

`define PAP_ASSERT(lbl, prop, msg)

`define PAP_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

// File: src/pap_pkg.sv
// Package for the preferential attachment picker: field widths, register indexes,
// payload structs and the command and status structs between controller and datapath.
// No dependencies.
package pap_pkg;

  localparam int DEF_MAX_NODES = 1024;
  localparam int DEF_MAX_LINKS = 16;

  localparam int NODE_FIELD_W = 10;
  localparam int NODE_COUNT_W = 11;
  localparam int LINKS_W      = 5;
  localparam int DEG_W        = 16;
  localparam int WORD_W       = 32;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [NODE_COUNT_W-1:0] NODE_COUNT_RESET = 11'd1000;
  localparam logic [LINKS_W-1:0]      LINKS_RESET      = 5'd10;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LINKS      = 1'd1;

  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_DRAW    = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] random_word;
  } pap_item_t;

  typedef struct packed {
    logic [NODE_FIELD_W-1:0] new_node;
    logic [NODE_FIELD_W-1:0] target_node;
    logic                    last_link_of_node;
    logic                    finished;
  } pap_result_t;

  typedef struct packed {
    logic load_item;
    logic core_init;
    logic core_write;
    logic walk_init;
    logic walk_issue;
    logic walk_acc;
    logic wr_target;
    logic wr_grow;
    logic emit_edge;
    logic emit_finished;
  } pap_cmd_t;

  typedef struct packed {
    logic is_draw;
    logic no_core;
    logic finished;
    logic core_done;
    logic walk_hit;
  } pap_status_t;

endpackage

// File: src/pap_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pap_ctrl.sv
// Controller state machine for the preferential attachment picker.
// Depends on pap_pkg and the assertion macro header.
`include "preferential_attachment_picker_macros.svh"

module pap_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pap_pkg::pap_status_t status,
  output pap_pkg::pap_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_CORE    = 3'd2;
  localparam logic [2:0] S_FILL    = 3'd3;
  localparam logic [2:0] S_WALK    = 3'd4;
  localparam logic [2:0] S_WR_TGT  = 3'd5;
  localparam logic [2:0] S_WR_GROW = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.is_draw) begin
          cmd.core_init = 1'b1;
          state_next    = S_CORE;
        end else if (status.no_core) begin
          state_next = S_IDLE;
        end else if (status.finished) begin
          cmd.emit_finished = 1'b1;
          state_next        = S_IDLE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_FILL;
        end
      end
      S_CORE: begin
        cmd.core_write = 1'b1;
        if (status.core_done) begin
          state_next = S_IDLE;
        end
      end
      S_FILL: begin
        cmd.walk_issue = 1'b1;
        state_next     = S_WALK;
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        cmd.walk_acc   = 1'b1;
        if (status.walk_hit) begin
          state_next = S_WR_TGT;
        end
      end
      S_WR_TGT: begin
        cmd.wr_target = 1'b1;
        state_next    = S_WR_GROW;
      end
      S_WR_GROW: begin
        cmd.wr_grow   = 1'b1;
        cmd.emit_edge = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `PAP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted item did not raise busy")
  `PAP_ASSERT(a_one_action, $onehot0({cmd.core_init, cmd.walk_init, cmd.emit_finished, cmd.emit_edge}), "Conflicting controller commands")
  `PAP_ASSERT_NEXT(a_wr_order, cmd.wr_target, cmd.wr_grow && cmd.emit_edge, "Target write not followed by growing node write")

endmodule

// File: src/pap_datapath.sv
// Datapath of the preferential attachment picker: configuration registers, growth state,
// degree RAM, pick multiplier, cumulative walk and result register.
// Depends on pap_pkg, pap_ram and the assertion macro header.
`include "preferential_attachment_picker_macros.svh"

module pap_datapath #(
  parameter int MAX_NODES          = pap_pkg::DEF_MAX_NODES,
  parameter int MAX_LINKS_PER_NODE = pap_pkg::DEF_MAX_LINKS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pap_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pap_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  pap_pkg::pap_item_t                  item,
  input  pap_pkg::pap_cmd_t                   cmd,
  output pap_pkg::pap_status_t                status,
  output logic                                done,
  output pap_pkg::pap_result_t                result
);

  localparam int AW      = $clog2(MAX_NODES);
  localparam int GROW_W  = $clog2(((MAX_NODES > MAX_LINKS_PER_NODE) ?
                                   MAX_NODES : MAX_LINKS_PER_NODE) + 1);
  localparam int CMP_W   = (GROW_W > pap_pkg::NODE_COUNT_W) ? GROW_W : pap_pkg::NODE_COUNT_W;
  localparam int SUM_W   = pap_pkg::DEG_W + AW;
  localparam int PROD_W  = pap_pkg::DEG_W + pap_pkg::WORD_W;
  localparam int LW      = pap_pkg::LINKS_W;
  localparam int DW      = pap_pkg::DEG_W;

  logic [pap_pkg::NODE_COUNT_W-1:0] node_count;
  logic [LW-1:0]                    links_per_node;
  logic                             kind;
  logic [pap_pkg::WORD_W-1:0]       random_word;
  logic [DW-1:0]                    total_degree;
  logic [GROW_W-1:0]                growing_node;
  logic [LW-1:0]                    link_index;
  logic [LW-1:0]                    core_cnt;
  logic [DW-1:0]                    pick;
  logic [SUM_W-1:0]                 sum;
  logic [AW-1:0]                    rd_addr;
  logic [AW-1:0]                    idx_d;
  logic [AW-1:0]                    target;
  logic [DW-1:0]                    target_deg;

  logic [LW-1:0]     links_min1;
  logic [LW-1:0]     eff_links;
  logic [LW-1:0]     core_last;
  logic [CMP_W-1:0]  grow_x;
  logic [CMP_W-1:0]  count_x;
  logic [AW-1:0]     grow_addr;
  logic [AW-1:0]     grow_m1;
  logic [SUM_W-1:0]  sum_next;
  logic [PROD_W-1:0] product;
  logic [DW-1:0]     rd_data;
  logic              last_link;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DW-1:0]     ram_wdata;

  assign links_min1 = (links_per_node == '0) ? LW'(1) : links_per_node;
  assign eff_links  = (int'(links_min1) > MAX_LINKS_PER_NODE) ?
                      LW'(MAX_LINKS_PER_NODE) : links_min1;
  assign core_last  = (int'(eff_links) > MAX_NODES) ? LW'(MAX_NODES - 1) :
                      eff_links - LW'(1);

  assign grow_x    = CMP_W'(growing_node);
  assign count_x   = (node_count < pap_pkg::NODE_COUNT_W'(2)) ? CMP_W'(2) : CMP_W'(node_count);
  assign grow_addr = AW'(growing_node);
  assign grow_m1   = grow_addr - AW'(1);
  assign sum_next  = sum + SUM_W'(rd_data);
  assign product   = PROD_W'(total_degree) * PROD_W'(random_word);
  assign last_link = (link_index >= eff_links - LW'(1));

  assign status.is_draw   = (kind == pap_pkg::KIND_DRAW);
  assign status.no_core   = (growing_node == '0);
  assign status.finished  = (grow_x >= count_x) || (grow_x >= CMP_W'(MAX_NODES));
  assign status.core_done = (core_cnt == core_last);
  assign status.walk_hit  = (sum_next > SUM_W'(pick)) || (idx_d == grow_m1);

  always_comb begin
    ram_we    = cmd.core_write | cmd.wr_target | cmd.wr_grow;
    ram_waddr = grow_addr;
    ram_wdata = DW'(link_index) + DW'(1);
    if (cmd.core_write) begin
      ram_waddr = AW'(core_cnt);
      ram_wdata = DW'(eff_links);
    end else if (cmd.wr_target) begin
      ram_waddr = target;
      ram_wdata = target_deg + DW'(1);
    end
  end

  pap_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_NODES)
  ) u_degree_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count     <= pap_pkg::NODE_COUNT_RESET;
      links_per_node <= pap_pkg::LINKS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pap_pkg::REG_NODE_COUNT: node_count     <= cfg_data;
        pap_pkg::REG_LINKS:      links_per_node <= cfg_data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_degree <= '0;
      growing_node <= '0;
      link_index   <= '0;
      done         <= 1'b0;
    end else begin
      done <= cmd.emit_edge | cmd.emit_finished;
      if (cmd.core_init) begin
        total_degree <= DW'(eff_links) * DW'(eff_links);
        growing_node <= GROW_W'(eff_links);
        link_index   <= '0;
      end else if (cmd.emit_edge) begin
        total_degree <= total_degree + DW'(2);
        if (last_link) begin
          link_index   <= '0;
          growing_node <= growing_node + GROW_W'(1);
        end else begin
          link_index <= link_index + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind        <= item.kind;
      random_word <= item.random_word;
    end
    if (cmd.core_init) begin
      core_cnt <= '0;
    end else if (cmd.core_write) begin
      core_cnt <= core_cnt + LW'(1);
    end
    if (cmd.walk_init) begin
      pick    <= product[PROD_W-1:pap_pkg::WORD_W];
      rd_addr <= '0;
      idx_d   <= '0;
      sum     <= '0;
    end else begin
      if (cmd.walk_issue) begin
        rd_addr <= rd_addr + AW'(1);
      end
      if (cmd.walk_acc) begin
        sum   <= sum_next;
        idx_d <= idx_d + AW'(1);
        if (status.walk_hit) begin
          target     <= idx_d;
          target_deg <= rd_data;
        end
      end
    end
    if (cmd.emit_edge) begin
      result.new_node          <= pap_pkg::NODE_FIELD_W'(growing_node);
      result.target_node       <= pap_pkg::NODE_FIELD_W'(target);
      result.last_link_of_node <= last_link;
      result.finished          <= 1'b0;
    end else if (cmd.emit_finished) begin
      result.new_node          <= '0;
      result.target_node       <= '0;
      result.last_link_of_node <= 1'b0;
      result.finished          <= 1'b1;
    end
  end

  `PAP_ASSERT(a_finished_clean, done && result.finished |-> result.new_node == '0 && result.target_node == '0 && !result.last_link_of_node, "Finished result carries edge data")
  `PAP_ASSERT_NEXT(a_single_strobe, done, !done, "Result strobe held for more than one cycle")
  `PAP_ASSERT(a_target_below, cmd.wr_target |-> target < grow_addr, "Picked target is not below the growing node")

endmodule

// File: src/preferential_attachment_picker.sv
// Top level of the preferential attachment picker.
// Joins pap_ctrl and pap_datapath; depends on pap_pkg.
//
// Usage: an item is transferred when start is high and busy is low. A restart item
// (kind 0) rebuilds the core from links_per_node, clamped to 1..MAX_LINKS_PER_NODE:
// the first that many degrees are set to that value and growth restarts at that node;
// it gives no result and keeps busy high while the core is written. A draw item
// (kind 1) scales the total degree by random_word, walks the degree RAM one entry per
// cycle and picks the first node whose running degree sum exceeds that pick, or the
// last node below the growing node. Its result appears on result with done high for
// exactly one cycle; busy falls in the same cycle, and the next item may be
// transferred then. A draw after all nodes are placed returns a result with finished
// set; a draw before any restart returns nothing.
// Configuration writes on cfg_write, cfg_index and cfg_data take effect at once.
// Reset restores the register defaults and leaves no core; the degree RAM needs no
// clearing pass, since a restart rewrites the core entries and growth writes each
// later entry before a walk reads it.
// The receiver cannot stall: each result must be taken in its done cycle.
module preferential_attachment_picker #(
  parameter int MAX_NODES          = pap_pkg::DEF_MAX_NODES,
  parameter int MAX_LINKS_PER_NODE = pap_pkg::DEF_MAX_LINKS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  pap_pkg::pap_item_t              item,
  output logic                            done,
  output pap_pkg::pap_result_t            result,
  input  logic                            cfg_write,
  input  logic [pap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pap_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pap_pkg::pap_cmd_t    cmd;
  pap_pkg::pap_status_t status;

  pap_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  pap_datapath #(
    .MAX_NODES          (MAX_NODES),
    .MAX_LINKS_PER_NODE (MAX_LINKS_PER_NODE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .status    (status),
    .done      (done),
    .result    (result)
  );

endmodule
